@@ hw/rtl/tbo_pkg.sv @@
`default_nettype none
package tbo_pkg;

    localparam int IN_W   = 32;           // input coordinate width
    localparam int SIZE_W = 31;           // box size register width
    localparam int CFG_IDX_W = 2;
    localparam int CW     = 36;           // doubled-unit coordinates and deltas
    localparam int PW     = 2 * CW;       // one full product
    localparam int SW     = PW + 2;       // sum or difference of two products
    localparam int NW     = PW;           // plane normal component
    localparam int HW     = 36;           // normal split point for plane products
    localparam int LW     = HW + 1 + CW;  // low partial product
    localparam int DW     = 108;          // plane distance accumulator
    localparam int NSTAGE = 6;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);

    // (k+1)%3 and (k+2)%3
    localparam int NXT  [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};
    // vertices projected on the x and y cross axes, then on the z cross axis, per edge
    localparam int PA_XY [3] = '{0, 0, 0};
    localparam int PB_XY [3] = '{2, 2, 1};
    localparam int PA_Z  [3] = '{1, 0, 1};
    localparam int PB_Z  [3] = '{2, 1, 2};

    typedef logic signed [IN_W-1:0] in_t;
    typedef logic [SIZE_W-1:0]      size_t;
    typedef logic signed [CW-1:0]   coord_t;
    typedef logic signed [PW-1:0]   prod_t;
    typedef logic signed [SW-1:0]   sum_t;
    typedef logic signed [NW-1:0]   norm_t;
    typedef logic signed [LW-1:0]   part_lo_t;
    typedef logic signed [PW-1:0]   part_hi_t;
    typedef logic signed [DW-1:0]   dot_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic in_box;
        logic seg_hit;
        logic axes_ok;
        logic extent_ok;
    } flags_t;

    function automatic coord_t cabs(input coord_t x);
        return (x < 0) ? -x : x;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tbo_prep.sv @@
`default_nettype none
module tbo_prep import tbo_pkg::*; (
    input  logic   clk,
    input  logic   en,
    input  in_t    corner [3],
    input  in_t    vtx [3][3],
    input  size_t  size [3],
    output logic   inside_reg,
    output coord_t v_reg [3][3],
    output coord_t d_reg [3][3],
    output coord_t m_reg [3][3],
    output coord_t ad_reg [3][3]
);

    coord_t cc [3];
    coord_t ss [3];
    coord_t tt [3][3];
    coord_t v_next [3][3];
    coord_t d_next [3][3];
    coord_t m_next [3][3];
    coord_t ad_next [3][3];
    logic   hit [3];
    logic   inside_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cc[k] = coord_t'(corner[k]);
            ss[k] = coord_t'(size[k]);
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                tt[i][k] = coord_t'(vtx[i][k]);
            end
        end
        inside_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            hit[i] = 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                v_next[i][k] = (tt[i][k] <<< 1) - (cc[k] <<< 1) - ss[k];
                if (!(tt[i][k] >= cc[k] && tt[i][k] < cc[k] + ss[k]))
                begin
                    hit[i] = 1'b0;
                end
                // segment from vertex i to the next one, raw units
                d_next[i][k]  = tt[NXT[i]][k] - tt[i][k];
                m_next[i][k]  = tt[i][k] + tt[NXT[i]][k] - (cc[k] <<< 1) - ss[k];
                ad_next[i][k] = cabs(d_next[i][k]);
            end
            inside_next = inside_next | hit[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg <= inside_next;
            v_reg      <= v_next;
            d_reg      <= d_next;
            m_reg      <= m_next;
            ad_reg     <= ad_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tbo_mult.sv @@
`default_nettype none
module tbo_mult import tbo_pkg::*; (
    input  logic       clk,
    input  logic       en,
    input  size_t      size [3],
    input  logic       in_box,
    input  coord_t     v [3][3],
    input  coord_t     d [3][3],
    input  coord_t     m [3][3],
    input  coord_t     ad [3][3],
    output logic       inside_reg,
    output logic [2:0] segbox_reg,
    output logic       extent_reg,
    output coord_t     v0_reg [3],
    output prod_t      sp1_reg [3][3],
    output prod_t      sp2_reg [3][3],
    output prod_t      sr1_reg [3][3],
    output prod_t      sr2_reg [3][3],
    output prod_t      ap0a_reg [3][3],
    output prod_t      ap0b_reg [3][3],
    output prod_t      ap1a_reg [3][3],
    output prod_t      ap1b_reg [3][3],
    output prod_t      ar1_reg [3][3],
    output prod_t      ar2_reg [3][3],
    output prod_t      np1_reg [3],
    output prod_t      np2_reg [3]
);

    coord_t     ss [3];
    coord_t     ee [3][3];
    coord_t     aee [3][3];
    logic [2:0] segbox_next;
    logic       extent_next;
    prod_t      sp1_next [3][3];
    prod_t      sp2_next [3][3];
    prod_t      sr1_next [3][3];
    prod_t      sr2_next [3][3];
    prod_t      ap0a_next [3][3];
    prod_t      ap0b_next [3][3];
    prod_t      ap1a_next [3][3];
    prod_t      ap1b_next [3][3];
    prod_t      ar1_next [3][3];
    prod_t      ar2_next [3][3];
    prod_t      np1_next [3];
    prod_t      np2_next [3];
    int         pa [3][3];
    int         pb [3][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ss[k] = coord_t'(size[k]);
        end
        // triangle edges in doubled units are twice the raw segment deltas
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ee[i][k]  = d[i][k] <<< 1;
                aee[i][k] = ad[i][k] <<< 1;
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            segbox_next[i] = 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                if (cabs(m[i][k]) > ss[k] + ad[i][k])
                begin
                    segbox_next[i] = 1'b0;
                end
                sp1_next[i][k] = d[i][NXT[k]] * m[i][NXT2[k]];
                sp2_next[i][k] = d[i][NXT2[k]] * m[i][NXT[k]];
                sr1_next[i][k] = ss[NXT[k]] * ad[i][NXT2[k]];
                sr2_next[i][k] = ss[NXT2[k]] * ad[i][NXT[k]];
            end
        end

        // edge i, cross axis a: c1 = e[i2], c2 = e[i1]
        for (int i = 0; i < 3; i++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                pa[i][a] = (a < 2) ? PA_XY[i] : PA_Z[i];
                pb[i][a] = (a < 2) ? PB_XY[i] : PB_Z[i];
                ap0a_next[i][a] = ee[i][NXT2[a]] * v[pa[i][a]][NXT[a]];
                ap0b_next[i][a] = ee[i][NXT[a]]  * v[pa[i][a]][NXT2[a]];
                ap1a_next[i][a] = ee[i][NXT2[a]] * v[pb[i][a]][NXT[a]];
                ap1b_next[i][a] = ee[i][NXT[a]]  * v[pb[i][a]][NXT2[a]];
                ar1_next[i][a]  = ss[NXT[a]]  * aee[i][NXT2[a]];
                ar2_next[i][a]  = ss[NXT2[a]] * aee[i][NXT[a]];
            end
        end

        for (int k = 0; k < 3; k++)
        begin
            np1_next[k] = ee[0][NXT[k]]  * ee[1][NXT2[k]];
            np2_next[k] = ee[0][NXT2[k]] * ee[1][NXT[k]];
        end

        // box-face extents: fails when all vertices lie beyond one face
        extent_next = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if ((v[0][k] > ss[k] && v[1][k] > ss[k] && v[2][k] > ss[k]) ||
                (v[0][k] < -ss[k] && v[1][k] < -ss[k] && v[2][k] < -ss[k]))
            begin
                extent_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg <= in_box;
            segbox_reg <= segbox_next;
            extent_reg <= extent_next;
            v0_reg     <= v[0];
            sp1_reg    <= sp1_next;
            sp2_reg    <= sp2_next;
            sr1_reg    <= sr1_next;
            sr2_reg    <= sr2_next;
            ap0a_reg   <= ap0a_next;
            ap0b_reg   <= ap0b_next;
            ap1a_reg   <= ap1a_next;
            ap1b_reg   <= ap1b_next;
            ar1_reg    <= ar1_next;
            ar2_reg    <= ar2_next;
            np1_reg    <= np1_next;
            np2_reg    <= np2_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tbo_reduce.sv @@
`default_nettype none
module tbo_reduce import tbo_pkg::*; (
    input  logic       clk,
    input  logic       en_c,
    input  logic       en_d,
    input  logic       in_box,
    input  logic [2:0] segbox,
    input  logic       extent,
    input  coord_t     v0 [3],
    input  prod_t      sp1 [3][3],
    input  prod_t      sp2 [3][3],
    input  prod_t      sr1 [3][3],
    input  prod_t      sr2 [3][3],
    input  prod_t      ap0a [3][3],
    input  prod_t      ap0b [3][3],
    input  prod_t      ap1a [3][3],
    input  prod_t      ap1b [3][3],
    input  prod_t      ar1 [3][3],
    input  prod_t      ar2 [3][3],
    input  prod_t      np1 [3],
    input  prod_t      np2 [3],
    output norm_t      n_reg [3],
    output coord_t     v0_reg [3],
    output flags_t     flags_reg
);

    // stage C: sums and differences of product pairs
    logic       inside_reg;
    logic [2:0] segbox_reg;
    logic       extent_reg;
    sum_t       sv_next [3][3];
    sum_t       sr_next [3][3];
    sum_t       p0_next [3][3];
    sum_t       p1_next [3][3];
    sum_t       rad_next [3][3];
    norm_t      n_next [3];
    sum_t       sv_reg [3][3];
    sum_t       sr_reg [3][3];
    sum_t       p0_reg [3][3];
    sum_t       p1_reg [3][3];
    sum_t       rad_reg [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sv_next[i][k]  = sum_t'(sp1[i][k]) - sum_t'(sp2[i][k]);
                sr_next[i][k]  = sum_t'(sr1[i][k]) + sum_t'(sr2[i][k]);
                p0_next[i][k]  = sum_t'(ap0a[i][k]) - sum_t'(ap0b[i][k]);
                p1_next[i][k]  = sum_t'(ap1a[i][k]) - sum_t'(ap1b[i][k]);
                rad_next[i][k] = sum_t'(ar1[i][k]) + sum_t'(ar2[i][k]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            n_next[k] = norm_t'(np1[k]) - norm_t'(np2[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            inside_reg <= in_box;
            segbox_reg <= segbox;
            extent_reg <= extent;
            v0_reg     <= v0;
            sv_reg     <= sv_next;
            sr_reg     <= sr_next;
            p0_reg     <= p0_next;
            p1_reg     <= p1_next;
            rad_reg    <= rad_next;
            n_reg      <= n_next;
        end
    end

    // stage D: compares
    logic   seg_ok [3];
    sum_t   sv_abs [3][3];
    flags_t flags_next;

    always_comb
    begin
        flags_next.in_box    = inside_reg;
        flags_next.extent_ok = extent_reg;
        flags_next.seg_hit   = 1'b0;
        flags_next.axes_ok   = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            seg_ok[i] = segbox_reg[i];
            for (int k = 0; k < 3; k++)
            begin
                sv_abs[i][k] = (sv_reg[i][k] < 0) ? -sv_reg[i][k] : sv_reg[i][k];
                if (sv_abs[i][k] > sr_reg[i][k])
                begin
                    seg_ok[i] = 1'b0;
                end
                // separated when both projections sit past the same side
                if ((p0_reg[i][k] > rad_reg[i][k] && p1_reg[i][k] > rad_reg[i][k]) ||
                    (p0_reg[i][k] < -rad_reg[i][k] && p1_reg[i][k] < -rad_reg[i][k]))
                begin
                    flags_next.axes_ok = 1'b0;
                end
            end
            flags_next.seg_hit = flags_next.seg_hit | seg_ok[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            flags_reg <= flags_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tbo_plane.sv @@
`default_nettype none
module tbo_plane import tbo_pkg::*; (
    input  logic   clk,
    input  logic   en_d,
    input  logic   en_e,
    input  logic   en_f,
    input  size_t  size [3],
    input  norm_t  n [3],
    input  coord_t v0 [3],
    output logic   plane_ok_reg
);

    // stage D: pick box corners by normal sign, split normal into two halves
    coord_t           ss [3];
    coord_t           lo_c [3];
    coord_t           hi_c [3];
    coord_t           amin [3];
    coord_t           amax [3];
    logic signed [HW:0]    nl [3];
    logic signed [NW-HW-1:0] nh [3];
    part_lo_t pl_min_next [3];
    part_lo_t pl_max_next [3];
    part_hi_t ph_min_next [3];
    part_hi_t ph_max_next [3];
    part_lo_t pl_min_reg [3];
    part_lo_t pl_max_reg [3];
    part_hi_t ph_min_reg [3];
    part_hi_t ph_max_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ss[k]   = coord_t'(size[k]);
            lo_c[k] = -ss[k] - v0[k];
            hi_c[k] = ss[k] - v0[k];
            amin[k] = (n[k] <= 0) ? hi_c[k] : lo_c[k];
            amax[k] = (n[k] <= 0) ? lo_c[k] : hi_c[k];
            nl[k]   = $signed({1'b0, n[k][HW-1:0]});
            nh[k]   = $signed(n[k][NW-1:HW]);
            pl_min_next[k] = nl[k] * amin[k];
            pl_max_next[k] = nl[k] * amax[k];
            ph_min_next[k] = nh[k] * amin[k];
            ph_max_next[k] = nh[k] * amax[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            pl_min_reg <= pl_min_next;
            pl_max_reg <= pl_max_next;
            ph_min_reg <= ph_min_next;
            ph_max_reg <= ph_max_next;
        end
    end

    // stage E: recombine partial products
    dot_t dmin_k_next [3];
    dot_t dmax_k_next [3];
    dot_t dmin_k_reg [3];
    dot_t dmax_k_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dmin_k_next[k] = (dot_t'(ph_min_reg[k]) <<< HW) + dot_t'(pl_min_reg[k]);
            dmax_k_next[k] = (dot_t'(ph_max_reg[k]) <<< HW) + dot_t'(pl_max_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            dmin_k_reg <= dmin_k_next;
            dmax_k_reg <= dmax_k_next;
        end
    end

    // stage F: plane distance range must straddle zero
    dot_t dmin;
    dot_t dmax;
    logic plane_ok_next;

    always_comb
    begin
        dmin = dmin_k_reg[0] + dmin_k_reg[1] + dmin_k_reg[2];
        dmax = dmax_k_reg[0] + dmax_k_reg[1] + dmax_k_reg[2];
        plane_ok_next = (dmin <= 0) && (dmax >= 0);
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            plane_ok_reg <= plane_ok_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/triangle_box_overlap_top.sv @@
// Triangle / box overlap, one query item in, one overlap flag out.
// Stages from input accept to out_valid: prep, products, sums, compares and
// plane partial products, plane product assembly, plane sum.
// Throughput: one item per cycle; each stage holds only while full and blocked.
// Reset: pipeline valid bits clear, box sizes return to 1.0 on all axes.
`default_nettype none
module triangle_box_overlap_top import tbo_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_t                  corner_x,
    input  in_t                  corner_y,
    input  in_t                  corner_z,
    input  in_t                  v0_x,
    input  in_t                  v0_y,
    input  in_t                  v0_z,
    input  in_t                  v1_x,
    input  in_t                  v1_y,
    input  in_t                  v1_z,
    input  in_t                  v2_x,
    input  in_t                  v2_y,
    input  in_t                  v2_z,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 overlap,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    // configuration
    size_t size_reg [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg[0] <= SIZE_RESET;
            size_reg[1] <= SIZE_RESET;
            size_reg[2] <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SIZE_X: size_reg[0] <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y: size_reg[1] <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Z: size_reg[2] <= cfg_data[SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    // stage valids; a stage loads when empty or when the next one moves
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] adv;

    always_comb
    begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || !out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        for (int k = 0; k < NSTAGE; k++)
        begin
            if (!adv[k])
            begin
                valid_next[k] = valid_reg[k];
            end
            else if (k == 0)
            begin
                valid_next[k] = in_valid;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[NSTAGE-1];

    in_t corner [3];
    in_t vtx [3][3];

    assign corner = '{corner_x, corner_y, corner_z};
    assign vtx = '{'{v0_x, v0_y, v0_z}, '{v1_x, v1_y, v1_z}, '{v2_x, v2_y, v2_z}};

    // stage A
    logic   a_inside;
    coord_t a_v [3][3];
    coord_t a_d [3][3];
    coord_t a_m [3][3];
    coord_t a_ad [3][3];

    tbo_prep u_prep (
        .clk        (clk),
        .en         (adv[0]),
        .corner     (corner),
        .vtx        (vtx),
        .size       (size_reg),
        .inside_reg (a_inside),
        .v_reg      (a_v),
        .d_reg      (a_d),
        .m_reg      (a_m),
        .ad_reg     (a_ad)
    );

    // stage B
    logic       b_inside;
    logic [2:0] b_segbox;
    logic       b_extent;
    coord_t     b_v0 [3];
    prod_t      b_sp1 [3][3];
    prod_t      b_sp2 [3][3];
    prod_t      b_sr1 [3][3];
    prod_t      b_sr2 [3][3];
    prod_t      b_ap0a [3][3];
    prod_t      b_ap0b [3][3];
    prod_t      b_ap1a [3][3];
    prod_t      b_ap1b [3][3];
    prod_t      b_ar1 [3][3];
    prod_t      b_ar2 [3][3];
    prod_t      b_np1 [3];
    prod_t      b_np2 [3];

    tbo_mult u_mult (
        .clk        (clk),
        .en         (adv[1]),
        .size       (size_reg),
        .in_box     (a_inside),
        .v          (a_v),
        .d          (a_d),
        .m          (a_m),
        .ad         (a_ad),
        .inside_reg (b_inside),
        .segbox_reg (b_segbox),
        .extent_reg (b_extent),
        .v0_reg     (b_v0),
        .sp1_reg    (b_sp1),
        .sp2_reg    (b_sp2),
        .sr1_reg    (b_sr1),
        .sr2_reg    (b_sr2),
        .ap0a_reg   (b_ap0a),
        .ap0b_reg   (b_ap0b),
        .ap1a_reg   (b_ap1a),
        .ap1b_reg   (b_ap1b),
        .ar1_reg    (b_ar1),
        .ar2_reg    (b_ar2),
        .np1_reg    (b_np1),
        .np2_reg    (b_np2)
    );

    // stages C and D
    norm_t  c_n [3];
    coord_t c_v0 [3];
    flags_t d_flags;

    tbo_reduce u_reduce (
        .clk       (clk),
        .en_c      (adv[2]),
        .en_d      (adv[3]),
        .in_box    (b_inside),
        .segbox    (b_segbox),
        .extent    (b_extent),
        .v0        (b_v0),
        .sp1       (b_sp1),
        .sp2       (b_sp2),
        .sr1       (b_sr1),
        .sr2       (b_sr2),
        .ap0a      (b_ap0a),
        .ap0b      (b_ap0b),
        .ap1a      (b_ap1a),
        .ap1b      (b_ap1b),
        .ar1       (b_ar1),
        .ar2       (b_ar2),
        .np1       (b_np1),
        .np2       (b_np2),
        .n_reg     (c_n),
        .v0_reg    (c_v0),
        .flags_reg (d_flags)
    );

    // stages D through F for the plane test
    logic f_plane_ok;

    tbo_plane u_plane (
        .clk          (clk),
        .en_d         (adv[3]),
        .en_e         (adv[4]),
        .en_f         (adv[5]),
        .size         (size_reg),
        .n            (c_n),
        .v0           (c_v0),
        .plane_ok_reg (f_plane_ok)
    );

    // flags ride along with the plane stages
    flags_t e_flags_reg;
    flags_t f_flags_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            e_flags_reg <= d_flags;
        end
        if (adv[5])
        begin
            f_flags_reg <= e_flags_reg;
        end
    end

    assign overlap = f_flags_reg.in_box || f_flags_reg.seg_hit ||
                     (f_flags_reg.axes_ok && f_flags_reg.extent_ok && f_plane_ok);

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tbo_pkg::*;

    typedef logic signed [63:0]  s64_t;
    typedef logic signed [127:0] s128_t;

    typedef struct {
        in_t c [3];
        in_t t [3][3];
    } query_t;

    // Exact fixed-point overlap predictor, doubled units.
    function automatic bit segment_hits(s64_t p [3], s64_t q [3], s64_t c [3], s64_t s [3]);
        s64_t d [3];
        s64_t m [3];
        s64_t ad [3];
        s128_t v;
        s128_t r;
        int i;
        int j;
        for (int k = 0; k < 3; k++)
        begin
            d[k] = q[k] - p[k];
            m[k] = p[k] + q[k] - 2 * c[k] - s[k];
            ad[k] = (d[k] < 0) ? -d[k] : d[k];
            if (((m[k] < 0) ? -m[k] : m[k]) > s[k] + ad[k])
                return 0;
        end
        for (int k = 0; k < 3; k++)
        begin
            i = (k + 1) % 3;
            j = (k + 2) % 3;
            v = s128_t'(d[i]) * m[j] - s128_t'(d[j]) * m[i];
            r = s128_t'(s[i]) * ad[j] + s128_t'(s[j]) * ad[i];
            if (v < 0)
                v = -v;
            if (v > r)
                return 0;
        end
        return 1;
    endfunction

    function automatic bit axis_ok(s64_t c1, s64_t c2, int i1, int i2,
                                   s64_t pv [3], s64_t qv [3], s64_t s [3]);
        s128_t p0;
        s128_t p1;
        s128_t rad;
        s128_t lo;
        s128_t hi;
        p0 = s128_t'(c1) * pv[i1] - s128_t'(c2) * pv[i2];
        p1 = s128_t'(c1) * qv[i1] - s128_t'(c2) * qv[i2];
        rad = s128_t'(s[i1]) * ((c1 < 0) ? -c1 : c1) + s128_t'(s[i2]) * ((c2 < 0) ? -c2 : c2);
        lo = (p1 < p0) ? p1 : p0;
        hi = (p1 < p0) ? p0 : p1;
        return !(lo > rad || hi < -rad);
    endfunction

    function automatic bit edge_axes(s64_t e [3], s64_t xa [3], s64_t xb [3],
                                     s64_t za [3], s64_t zb [3], s64_t s [3]);
        return axis_ok(e[2], e[1], 1, 2, xa, xb, s) && axis_ok(e[0], e[2], 2, 0, xa, xb, s)
            && axis_ok(e[1], e[0], 0, 1, za, zb, s);
    endfunction

    function automatic bit predict_overlap(query_t qy, s64_t s [3]);
        s64_t c [3];
        s64_t t [3][3];
        s64_t v [3][3];
        s64_t e0 [3];
        s64_t e1 [3];
        s64_t e2 [3];
        s128_t n [3];
        s128_t dmin;
        s128_t dmax;
        s64_t a;
        s64_t b;
        s64_t tmp;
        s64_t lo;
        s64_t hi;
        for (int k = 0; k < 3; k++)
        begin
            c[k] = qy.c[k];
            for (int i = 0; i < 3; i++)
                t[i][k] = qy.t[i][k];
        end
        for (int i = 0; i < 3; i++)
            if (t[i][0] >= c[0] && t[i][1] >= c[1] && t[i][2] >= c[2] && t[i][0] < c[0] + s[0]
                && t[i][1] < c[1] + s[1] && t[i][2] < c[2] + s[2])
                return 1;
        for (int i = 0; i < 3; i++)
            if (segment_hits(t[i], t[(i + 1) % 3], c, s))
                return 1;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                v[i][k] = 2 * t[i][k] - 2 * c[k] - s[k];
        for (int k = 0; k < 3; k++)
        begin
            e0[k] = v[1][k] - v[0][k];
            e1[k] = v[2][k] - v[1][k];
            e2[k] = v[0][k] - v[2][k];
        end
        if (!edge_axes(e0, v[0], v[2], v[1], v[2], s))
            return 0;
        if (!edge_axes(e1, v[0], v[2], v[0], v[1], s))
            return 0;
        if (!edge_axes(e2, v[0], v[1], v[1], v[2], s))
            return 0;
        for (int k = 0; k < 3; k++)
        begin
            lo = v[0][k];
            hi = v[0][k];
            for (int i = 1; i < 3; i++)
            begin
                if (v[i][k] < lo)
                    lo = v[i][k];
                if (v[i][k] > hi)
                    hi = v[i][k];
            end
            if (lo > s[k] || hi < -s[k])
                return 0;
        end
        n[0] = s128_t'(e0[1]) * e1[2] - s128_t'(e0[2]) * e1[1];
        n[1] = s128_t'(e0[2]) * e1[0] - s128_t'(e0[0]) * e1[2];
        n[2] = s128_t'(e0[0]) * e1[1] - s128_t'(e0[1]) * e1[0];
        dmin = 0;
        dmax = 0;
        for (int k = 0; k < 3; k++)
        begin
            a = -s[k] - v[0][k];
            b = s[k] - v[0][k];
            if (n[k] <= 0)
            begin
                tmp = a;
                a = b;
                b = tmp;
            end
            dmin += n[k] * a;
            dmax += n[k] * b;
        end
        if (dmin > 0)
            return 0;
        return dmax >= 0;
    endfunction

    class overlap_board;
        bit pending [$];
        int errors;
        s64_t box [3];

        function new();
            errors = 0;
            box[0] = 65536;
            box[1] = 65536;
            box[2] = 65536;
        endfunction

        function void note_query(query_t qy);
            pending.push_back(predict_overlap(qy, box));
        endfunction

        function void check_flag(logic got);
            bit want;
            if (pending.size() == 0)
            begin
                $error("overlap: unexpected item, actual %0b", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $error("overlap: expected %0b actual %0b", want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    in_t corner_x = 0, corner_y = 0, corner_z = 0;
    in_t v0_x = 0, v0_y = 0, v0_z = 0;
    in_t v1_x = 0, v1_y = 0, v1_z = 0;
    in_t v2_x = 0, v2_y = 0, v2_z = 0;
    logic out_valid;
    logic out_stall = 0;
    logic overlap;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [31:0] cfg_data = 0;

    overlap_board board = new();
    int unsigned cycles = 0;
    localparam int unsigned CYCLE_LIMIT = 400000;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    triangle_box_overlap_top dut (.*);

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver: check results and stall at random
    int stall_left = 0;
    bit calm = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_flag(overlap);
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left <= gap_len();
                out_stall <= 1;
            end
            else
                out_stall <= 0;
        end
    end

    // in_valid drops only for a gap; drain clears it after the last item
    task automatic send_query(query_t qy);
        int g;
        g = calm ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        corner_x <= qy.c[0]; corner_y <= qy.c[1]; corner_z <= qy.c[2];
        v0_x <= qy.t[0][0]; v0_y <= qy.t[0][1]; v0_z <= qy.t[0][2];
        v1_x <= qy.t[1][0]; v1_y <= qy.t[1][1]; v1_z <= qy.t[1][2];
        v2_x <= qy.t[2][0]; v2_y <= qy.t[2][1]; v2_z <= qy.t[2][2];
        in_valid <= 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_query(qy);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (NSTAGE + 4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        board.box[idx] = val & 32'h7fff_ffff;
        @(posedge clk);
    endtask

    function automatic in_t rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 2000000)) - 1000000;
            default: return $signed($urandom_range(0, 400000)) - 100000;
        endcase
    endfunction

    // Triangles near the box so that every test stage gets exercised.
    function automatic query_t rand_query();
        query_t qy;
        int mode;
        mode = $urandom_range(0, 9);
        mode = (mode == 0) ? 0 : (mode < 4 ? 1 : 2);
        for (int k = 0; k < 3; k++)
        begin
            qy.c[k] = (mode == 0) ? in_t'($urandom()) : rand_coord(2) - 32768;
            for (int i = 0; i < 3; i++)
                qy.t[i][k] = rand_coord(mode);
        end
        if ($urandom_range(0, 7) == 0)
            qy.t[2] = qy.t[$urandom_range(0, 1)];
        return qy;
    endfunction

    function automatic query_t fill_query(in_t cv, in_t tv [3]);
        query_t qy;
        for (int k = 0; k < 3; k++)
        begin
            qy.c[k] = cv;
            qy.t[k] = '{tv[k], tv[(k + 1) % 3], tv[(k + 2) % 3]};
        end
        return qy;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_query(rand_query());
    endtask

    initial
    begin
        in_t big [3];
        query_t qy;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, vertex inside, edge crossing, degenerate triangle
        big = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0};
        send_query(fill_query(32'sh8000_0000, big));
        send_query(fill_query(32'sh7fff_ffff, big));
        big = '{32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000};
        send_query(fill_query(0, big));
        big = '{-32'sh0001_0000, 32'sh0002_0000, 32'sh0000_8000};
        send_query(fill_query(0, big));
        big = '{32'sh0003_0000, 32'sh0003_0000, 32'sh0003_0000};
        send_query(fill_query(0, big));
        big = '{32'sh0001_0000, 32'sh0000_0000, 32'sh0000_ffff};
        send_query(fill_query(0, big));
        for (int i = 0; i < 12; i++)
            send_query(rand_query());
        drain();

        write_reg(REG_SIZE_X, 0);
        write_reg(REG_SIZE_Y, 0);
        write_reg(REG_SIZE_Z, 0);
        send_query(fill_query(0, '{0, 0, 0}));
        run_random(150);
        drain();

        write_reg(REG_SIZE_X, 32'hffff_ffff);
        write_reg(REG_SIZE_Y, 32'h7fff_ffff);
        write_reg(REG_SIZE_Z, 32'h7fff_fffe);
        big = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000};
        send_query(fill_query(32'sh8000_0000, big));
        run_random(150);

        // hold off until the pipe is empty, then push back to back
        drain();
        calm = 1;
        run_random(60);
        calm = 0;
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(REG_SIZE_X, $urandom_range(1, 300000));
            write_reg(REG_SIZE_Y, $urandom_range(1, 300000));
            write_reg(REG_SIZE_Z, $urandom_range(1, 300000));
            run_random(130);
            drain();
        end

        if (board.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
`default_nettype wire
